>>> src/alle_pkg.sv
// Shared constants, codes and interface structs for the linked list engine.
// No dependencies; every other file imports this package.
package alle_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 8;
	localparam int SLOT_W     = $clog2(CAPACITY);
	localparam int LINK_W     = $clog2(CAPACITY + 1);
	localparam int MODE_W     = 2;
	localparam int POS_W      = 5;
	localparam int CNT_W      = 5;
	localparam int STATUS_W   = 2;

	localparam logic [LINK_W-1:0] END_MARK = LINK_W'(CAPACITY);

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_BADPOS = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef struct packed {
		logic                  rd_en;
		logic [SLOT_W-1:0]     rd_addr;
		logic                  lk_we;
		logic [SLOT_W-1:0]     lk_waddr;
		logic [LINK_W-1:0]     lk_wdata;
		logic                  val_we;
		logic [SLOT_W-1:0]     val_waddr;
		logic [DATA_WIDTH-1:0] val_wdata;
	} mem_req_t;

	typedef struct packed {
		logic [LINK_W-1:0]     link;
		logic [DATA_WIDTH-1:0] value;
	} mem_rsp_t;

	typedef struct packed {
		logic                  valid;
		status_t               status;
		logic [DATA_WIDTH-1:0] element;
		logic [CNT_W-1:0]      count;
		logic                  last;
	} res_t;

endpackage

>>> src/alle_if.sv
// Valid/ready channel interfaces for the request and result sides.
// Depends on alle_pkg for field widths.
interface alle_req_if import alle_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [MODE_W-1:0]     mode;
	logic [POS_W-1:0]      position;
	logic [DATA_WIDTH-1:0] value;

	modport source (output valid, mode, position, value, input ready);
	modport sink (input valid, mode, position, value, output ready);
endinterface

interface alle_rsp_if import alle_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [DATA_WIDTH-1:0] element;
	logic [CNT_W-1:0]      count;
	logic                  last;

	modport source (output valid, status, element, count, last, input ready);
	modport sink (input valid, status, element, count, last, output ready);
endinterface

>>> src/alle_node_mem.sv
// Node storage: link memory with per-entry valid bits and value memory.
// One shared read address, registered read data. Depends on alle_pkg.
module alle_node_mem import alle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t mem_req,
	output mem_rsp_t mem_rsp
);

	logic [LINK_W-1:0]     link_mem [CAPACITY];
	logic [DATA_WIDTH-1:0] val_mem  [CAPACITY];
	logic [CAPACITY-1:0]   lk_vld_q;

	logic [LINK_W-1:0]     rd_link_q;
	logic [DATA_WIDTH-1:0] rd_val_q;
	logic [SLOT_W-1:0]     rd_addr_q;
	logic                  rd_vld_q;

	always_ff @(posedge clk) begin
		if (mem_req.lk_we) begin
			link_mem[mem_req.lk_waddr] <= mem_req.lk_wdata;
		end
		if (mem_req.val_we) begin
			val_mem[mem_req.val_waddr] <= mem_req.val_wdata;
		end
		if (mem_req.rd_en) begin
			rd_link_q <= link_mem[mem_req.rd_addr];
			rd_val_q  <= val_mem[mem_req.rd_addr];
			rd_addr_q <= mem_req.rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lk_vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_req.lk_we) begin
				lk_vld_q[mem_req.lk_waddr] <= 1'b1;
			end
			if (mem_req.rd_en) begin
				rd_vld_q <= lk_vld_q[mem_req.rd_addr];
			end
		end
	end

	// an unwritten link entry i reads as i + 1
	assign mem_rsp.link  = rd_vld_q ? rd_link_q : (LINK_W'(rd_addr_q) + LINK_W'(1));
	assign mem_rsp.value = rd_val_q;

endmodule

>>> src/alle_ctrl.sv
// Operation sequencer: checks, list walk, read-modify-write of node links.
// Holds head, free head and count. Depends on alle_pkg and alle_if.
module alle_ctrl import alle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	alle_req_if.sink   req,
	input  logic       res_take,
	output res_t       res,
	output mem_req_t   mem_req,
	input  mem_rsp_t   mem_rsp
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CHK   = 9'b000000010,
		S_SPARE = 9'b000000100,
		S_WALK  = 9'b000001000,
		S_INS_B = 9'b000010000,
		S_RCUR  = 9'b000100000,
		S_REM_B = 9'b001000000,
		S_DUMP  = 9'b010000000,
		S_EMIT  = 9'b100000000
	} state_t;

	state_t                state_q;
	logic [MODE_W-1:0]     mode_q;
	logic [POS_W-1:0]      pos_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [LINK_W-1:0]     head_q;
	logic [LINK_W-1:0]     free_q;
	logic [CNT_W-1:0]      count_q;
	logic [LINK_W-1:0]     prev_q;
	logic [LINK_W-1:0]     cur_q;
	logic [LINK_W-1:0]     spare_q;
	logic [POS_W-1:0]      rem_q;
	status_t               res_status_q;
	logic [DATA_WIDTH-1:0] res_elem_q;
	logic                  res_last_q;

	logic ins_full, ins_badpos, ins_nofree, rem_empty, rem_badpos, dump_empty;
	logic is_ins, is_rem, is_dump, pos_zero, rem_zero;

	assign is_ins     = (mode_q == MODE_INSERT);
	assign is_rem     = (mode_q == MODE_REMOVE);
	assign is_dump    = (mode_q == MODE_DUMP);
	assign pos_zero   = (pos_q == '0);
	assign rem_zero   = (rem_q == '0);
	assign ins_full   = (count_q >= CNT_W'(CAPACITY));
	assign ins_badpos = (pos_q > POS_W'(count_q));
	assign ins_nofree = (free_q >= END_MARK);
	assign rem_empty  = (count_q == '0);
	assign rem_badpos = (pos_q >= POS_W'(count_q));
	assign dump_empty = (count_q == '0);

	assign req.ready = (state_q == S_IDLE);

	assign res.valid   = (state_q == S_EMIT);
	assign res.status  = res_status_q;
	assign res.element = res_elem_q;
	assign res.count   = count_q;
	assign res.last    = res_last_q;

	// memory requests
	always_comb begin
		mem_req = '0;
		mem_req.val_waddr = free_q[SLOT_W-1:0];
		mem_req.val_wdata = val_q;
		unique case (state_q)
			S_CHK: begin
				if (is_ins) begin
					mem_req.rd_en   = !(ins_full || ins_badpos || ins_nofree);
					mem_req.rd_addr = free_q[SLOT_W-1:0];
				end else if (is_rem) begin
					mem_req.rd_en   = !(rem_empty || rem_badpos);
					mem_req.rd_addr = head_q[SLOT_W-1:0];
				end else if (is_dump) begin
					mem_req.rd_en   = !dump_empty;
					mem_req.rd_addr = head_q[SLOT_W-1:0];
				end
			end
			S_SPARE: begin
				if (pos_zero) begin
					mem_req.lk_we    = 1'b1;
					mem_req.lk_waddr = free_q[SLOT_W-1:0];
					mem_req.lk_wdata = head_q;
					mem_req.val_we   = 1'b1;
				end else begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = head_q[SLOT_W-1:0];
				end
			end
			S_WALK: begin
				if (rem_zero && is_ins) begin
					mem_req.lk_we    = 1'b1;
					mem_req.lk_waddr = free_q[SLOT_W-1:0];
					mem_req.lk_wdata = mem_rsp.link;
					mem_req.val_we   = 1'b1;
				end else begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = mem_rsp.link[SLOT_W-1:0];
				end
			end
			S_INS_B: begin
				mem_req.lk_we    = 1'b1;
				mem_req.lk_waddr = prev_q[SLOT_W-1:0];
				mem_req.lk_wdata = free_q;
			end
			S_RCUR: begin
				mem_req.lk_we = 1'b1;
				if (pos_zero) begin
					mem_req.lk_waddr = cur_q[SLOT_W-1:0];
					mem_req.lk_wdata = free_q;
				end else begin
					mem_req.lk_waddr = prev_q[SLOT_W-1:0];
					mem_req.lk_wdata = mem_rsp.link;
				end
			end
			S_REM_B: begin
				mem_req.lk_we    = 1'b1;
				mem_req.lk_waddr = cur_q[SLOT_W-1:0];
				mem_req.lk_wdata = free_q;
			end
			S_EMIT: begin
				mem_req.rd_en   = res_take && !res_last_q;
				mem_req.rd_addr = cur_q[SLOT_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= '0;
			pos_q        <= '0;
			val_q        <= '0;
			head_q       <= END_MARK;
			free_q       <= '0;
			count_q      <= '0;
			prev_q       <= '0;
			cur_q        <= '0;
			spare_q      <= '0;
			rem_q        <= '0;
			res_status_q <= ST_OK;
			res_elem_q   <= '0;
			res_last_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						mode_q  <= req.mode;
						pos_q   <= req.position;
						val_q   <= req.value;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					res_status_q <= ST_OK;
					res_elem_q   <= '0;
					res_last_q   <= 1'b1;
					state_q      <= S_EMIT;
					if (is_ins) begin
						priority if (ins_full) begin
							res_status_q <= ST_FULL;
						end else if (ins_badpos) begin
							res_status_q <= ST_BADPOS;
						end else if (ins_nofree) begin
							res_status_q <= ST_FULL;
						end else begin
							state_q <= S_SPARE;
						end
					end else if (is_rem) begin
						priority if (rem_empty) begin
							res_status_q <= ST_EMPTY;
						end else if (rem_badpos) begin
							res_status_q <= ST_BADPOS;
						end else if (pos_zero) begin
							cur_q   <= head_q;
							state_q <= S_RCUR;
						end else begin
							prev_q  <= head_q;
							rem_q   <= pos_q - POS_W'(1);
							state_q <= S_WALK;
						end
					end else if (is_dump) begin
						if (dump_empty) begin
							res_status_q <= ST_EMPTY;
						end else begin
							cur_q   <= head_q;
							rem_q   <= POS_W'(count_q - CNT_W'(1));
							state_q <= S_DUMP;
						end
					end
				end
				S_SPARE: begin
					// read data holds the link of the free head slot
					if (pos_zero) begin
						head_q  <= free_q;
						free_q  <= mem_rsp.link;
						count_q <= count_q + CNT_W'(1);
						state_q <= S_EMIT;
					end else begin
						spare_q <= mem_rsp.link;
						prev_q  <= head_q;
						rem_q   <= pos_q - POS_W'(1);
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					// read data holds the link of prev_q
					if (rem_zero) begin
						if (is_ins) begin
							state_q <= S_INS_B;
						end else begin
							cur_q   <= mem_rsp.link;
							state_q <= S_RCUR;
						end
					end else begin
						prev_q <= mem_rsp.link;
						rem_q  <= rem_q - POS_W'(1);
					end
				end
				S_INS_B: begin
					free_q  <= spare_q;
					count_q <= count_q + CNT_W'(1);
					state_q <= S_EMIT;
				end
				S_RCUR: begin
					res_elem_q <= mem_rsp.value;
					if (pos_zero) begin
						head_q  <= mem_rsp.link;
						free_q  <= cur_q;
						count_q <= count_q - CNT_W'(1);
						state_q <= S_EMIT;
					end else begin
						state_q <= S_REM_B;
					end
				end
				S_REM_B: begin
					free_q  <= cur_q;
					count_q <= count_q - CNT_W'(1);
					state_q <= S_EMIT;
				end
				S_DUMP: begin
					res_status_q <= ST_OK;
					res_elem_q   <= mem_rsp.value;
					res_last_q   <= rem_zero;
					cur_q        <= mem_rsp.link;
					state_q      <= S_EMIT;
				end
				S_EMIT: begin
					if (res_take) begin
						if (res_last_q) begin
							state_q <= S_IDLE;
						end else begin
							rem_q   <= rem_q - POS_W'(1);
							state_q <= S_DUMP;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> src/array_linked_list_engine_core.sv
// Linked list engine top level: sequencer, node memories and result register.
// Depends on alle_pkg, alle_if, alle_node_mem and alle_ctrl.
//
// Positional linked list of CAPACITY nodes kept in a link memory and a value
// memory, with unused slots chained on a free list. One request at a time is
// taken on req; each insert or remove gives one result, a dump gives one
// result per element in list order with last set on the final one. An insert
// or a remove at position p above zero walks to the node before position p,
// reading one link per cycle through the single read port of the node
// memory; at position zero there is no walk. A dump reads each next element
// only after the previous result has been taken into the output register.
// Error results (full, bad position, empty) and the ignored unused mode come
// straight out of the checks. Results sit in an output register, so the
// sequencer moves on while one waits on rsp.
// The link memory starts out as the free chain through valid bits cleared at
// reset, so no clearing pass is needed and req is ready right after reset.
module array_linked_list_engine_core import alle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	alle_req_if.sink   req,
	alle_rsp_if.source rsp
);

	mem_req_t mem_req;
	mem_rsp_t mem_rsp;
	res_t     res;
	logic     res_take;
	logic     out_free;

	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [DATA_WIDTH-1:0] out_elem_q;
	logic [CNT_W-1:0]      out_count_q;
	logic                  out_last_q;

	alle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.res_take (res_take),
		.res      (res),
		.mem_req  (mem_req),
		.mem_rsp  (mem_rsp)
	);

	alle_node_mem u_node_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.mem_req (mem_req),
		.mem_rsp (mem_rsp)
	);

	// the output register is free when empty or being drained this cycle
	assign out_free = !out_valid_q || rsp.ready;
	assign res_take = res.valid && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold payload until the transfer on rsp
	always_ff @(posedge clk) begin
		if (res_take) begin
			out_status_q <= res.status;
			out_elem_q   <= res.element;
			out_count_q  <= res.count;
			out_last_q   <= res.last;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.status  = out_status_q;
	assign rsp.element = out_elem_q;
	assign rsp.count   = out_count_q;
	assign rsp.last    = out_last_q;

endmodule
